/* rtl/lhm_pkg.sv */
// Shared types, constants and helper functions for the latency histogram monitor.
`default_nettype none
package lhm_pkg;
    localparam int NUM_STAGES = 7;
    localparam int NUM_BOUNDS = 17;
    localparam int NUM_BINS   = NUM_BOUNDS + 1;
    localparam int STAGE_W    = 3;
    localparam int BIN_W      = $clog2(NUM_BINS);
    localparam int MEM_DEPTH  = NUM_STAGES * NUM_BINS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PCT_W      = 7;
    localparam int PROD_W     = 64 + PCT_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [PCT_W-1:0] PCT_FIRST_RST  = 7'd50;
    localparam logic [PCT_W-1:0] PCT_SECOND_RST = 7'd95;
    localparam logic [PCT_W-1:0] PCT_THIRD_RST  = 7'd99;
    localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_QUERY   = 1'b1;

    typedef enum logic [1:0] {
        REG_PCT_FIRST  = 2'd0,
        REG_PCT_SECOND = 2'd1,
        REG_PCT_THIRD  = 2'd2
    } reg_idx_t;

    // Classified work item passed from front to back.
    typedef struct packed {
        logic               query;
        logic [STAGE_W-1:0] stage;
        logic [63:0]        duration;
        logic               ok_flag;
        logic [BIN_W-1:0]   bin;
    } work_t;

    // Bin bound in microseconds: m[i mod 3] * 10^(i/3 + 1).
    function automatic logic [63:0] bound_us(input logic [BIN_W-1:0] i);
        logic [63:0] v;
        logic [63:0] scale;
        int          m;
        v     = '0;
        scale = 64'd10;
        m     = 0;
        // table walk: mantissa 5, 10, 20, then the next decade
        for (int j = 0; j < NUM_BOUNDS; j++)
        begin
            if (i == BIN_W'(j))
            begin
                case (m)
                    0:       v = scale * 64'd5;
                    1:       v = scale * 64'd10;
                    default: v = scale * 64'd20;
                endcase
            end
            if (m == 2)
            begin
                m     = 0;
                scale = scale * 64'd10;
            end
            else
                m = m + 1;
        end
        return v;
    endfunction

    function automatic logic [63:0] bound_ns(input logic [BIN_W-1:0] i);
        return bound_us(i) * 64'd1000;
    endfunction

    function automatic logic [63:0] sat_inc(input logic [63:0] v);
        return (v == '1) ? v : v + 64'd1;
    endfunction
endpackage
`default_nettype wire

/* rtl/lhm_front.sv */
// Front end: accepts items, picks the histogram bin from the duration, pushes to the queue.
`default_nettype none
module lhm_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         operation,
    input  wire logic [lhm_pkg::STAGE_W-1:0]  stage,
    input  wire logic [63:0]                  duration,
    input  wire logic                         ok_flag,
    output logic                              push,
    output lhm_pkg::work_t                    push_item,
    input  wire logic                         q_full
);
    // The item is registered; the comparison against the bound table is combinational on the registered item.
    logic           s_valid_reg;
    lhm_pkg::work_t s_item_reg;
    logic [lhm_pkg::BIN_W-1:0] bin_sel;
    logic           take;

    assign in_ready = !s_valid_reg || (push && !q_full);
    assign take     = in_valid && in_ready;

    // bin: count bounds below duration in ns (us > bound  <=>  dur >= (bound+1)*1000)
    always_comb
    begin
        bin_sel = '0;
        for (int i = 0; i < lhm_pkg::NUM_BOUNDS; i++)
        begin
            if (s_item_reg.duration >= lhm_pkg::bound_ns(lhm_pkg::BIN_W'(i)) + 64'd1000)
                bin_sel = bin_sel + 1'b1;
        end
    end

    assign push = s_valid_reg && !q_full;
    always_comb
    begin
        push_item     = s_item_reg;
        push_item.bin = bin_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (take)
            s_valid_reg <= (int'(stage) < lhm_pkg::NUM_STAGES);
        else if (push)
            s_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_item_reg.query    <= (operation == lhm_pkg::OP_QUERY);
            s_item_reg.stage    <= stage;
            s_item_reg.duration <= duration;
            s_item_reg.ok_flag  <= ok_flag;
            s_item_reg.bin      <= '0;
        end
    end
endmodule
`default_nettype wire

/* rtl/lhm_queue.sv */
// Short FIFO between the front end and the back end.
`default_nettype none
module lhm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lhm_pkg::work_t push_item,
    output logic                full,
    input  wire logic           pop,
    output lhm_pkg::work_t      head,
    output logic                not_empty
);
    lhm_pkg::work_t                  slot_reg [lhm_pkg::QDEPTH];
    logic [lhm_pkg::QPTR_W-1:0]      wr_reg;
    logic [lhm_pkg::QPTR_W-1:0]      rd_reg;
    logic [lhm_pkg::QPTR_W:0]        cnt_reg;

    assign full      = (cnt_reg == (lhm_pkg::QPTR_W+1)'(lhm_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_item;
    end
endmodule
`default_nettype wire

/* rtl/lhm_back.sv */
// Back end: per-stage statistics, bin memory, percentile scan and result register.
`default_nettype none
module lhm_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lhm_pkg::work_t                head,
    input  wire logic                          not_empty,
    output logic                               pop,
    input  wire logic [lhm_pkg::PCT_W-1:0]     pct_first,
    input  wire logic [lhm_pkg::PCT_W-1:0]     pct_second,
    input  wire logic [lhm_pkg::PCT_W-1:0]     pct_third,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lhm_pkg::STAGE_W-1:0]        stage_echo,
    output logic [63:0]                        event_count,
    output logic [63:0]                        error_count,
    output logic [63:0]                        latency_sum,
    output logic [63:0]                        latency_min,
    output logic [63:0]                        latency_max,
    output logic [63:0]                        pct_first_value,
    output logic [63:0]                        pct_second_value,
    output logic [63:0]                        pct_third_value
);
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_OBS   = 9'b000000010,
        ST_TGT1  = 9'b000000100,
        ST_TGT2  = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_SCANW = 9'b000100000,
        ST_DONE  = 9'b001000000,
        ST_CLR   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] ev_reg  [lhm_pkg::NUM_STAGES];
    logic [63:0] er_reg  [lhm_pkg::NUM_STAGES];
    logic [63:0] sum_reg [lhm_pkg::NUM_STAGES];
    logic [63:0] min_reg [lhm_pkg::NUM_STAGES];
    logic [63:0] max_reg [lhm_pkg::NUM_STAGES];

    logic [63:0] bin_mem [lhm_pkg::MEM_DEPTH];
    logic [63:0] rd_data_reg;

    lhm_pkg::work_t            cur_reg;
    logic [lhm_pkg::ADDR_W-1:0] clr_reg;
    logic [lhm_pkg::BIN_W-1:0] scan_reg;
    logic [63:0]               seen_reg [3];
    logic [2:0]                found_reg;
    logic [63:0]               pv_reg   [3];
    logic [lhm_pkg::PROD_W-1:0] tgt_reg [3];
    logic [1:0]                tsel_reg;

    logic [lhm_pkg::STAGE_W-1:0] s;
    logic [lhm_pkg::ADDR_W-1:0]  base;
    logic [lhm_pkg::ADDR_W-1:0]  rd_addr;
    logic [63:0]                 cnt;
    logic [lhm_pkg::PCT_W-1:0]   pct [3];
    logic [63:0]                 seen_n [3];
    logic [lhm_pkg::PROD_W-1:0]  seen_x100 [3];

    assign s    = cur_reg.stage;
    assign base = lhm_pkg::ADDR_W'(int'(s) * lhm_pkg::NUM_BINS);
    assign cnt  = ev_reg[s];

    always_comb
    begin
        pct[0] = (pct_first  > lhm_pkg::PCT_MAX) ? lhm_pkg::PCT_MAX : pct_first;
        pct[1] = (pct_second > lhm_pkg::PCT_MAX) ? lhm_pkg::PCT_MAX : pct_second;
        pct[2] = (pct_third  > lhm_pkg::PCT_MAX) ? lhm_pkg::PCT_MAX : pct_third;
    end

    // seen >= ceil(cnt*pct/100)  <=>  100*seen >= cnt*pct
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            seen_n[k]    = (seen_reg[k] > ~rd_data_reg) ? '1 : seen_reg[k] + rd_data_reg;
            seen_x100[k] = (lhm_pkg::PROD_W'(seen_n[k]) << 6)
                         + (lhm_pkg::PROD_W'(seen_n[k]) << 5)
                         + (lhm_pkg::PROD_W'(seen_n[k]) << 2);
        end
    end

    assign pop = (state_reg == ST_IDLE) && not_empty;

    always_comb
    begin
        if (state_reg == ST_CLR)
            rd_addr = clr_reg;
        else if (state_reg == ST_IDLE)
            rd_addr = lhm_pkg::ADDR_W'(int'(head.stage) * lhm_pkg::NUM_BINS + int'(head.bin));
        else
            rd_addr = base + lhm_pkg::ADDR_W'(scan_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLR:   if (int'(clr_reg) == lhm_pkg::MEM_DEPTH - 1) state_next = ST_IDLE;
            ST_IDLE:  if (not_empty) state_next = head.query ? ST_TGT1 : ST_OBS;
            ST_OBS:   state_next = ST_IDLE;
            ST_TGT1:  state_next = ST_TGT2;
            ST_TGT2:  state_next = (tsel_reg == 2'd2) ? ST_SCANW : ST_TGT1;
            ST_SCANW: state_next = ST_SCAN;
            ST_SCAN:  if (int'(scan_reg) == lhm_pkg::NUM_BINS - 1) state_next = ST_DONE;
                      else state_next = ST_SCANW;
            ST_DONE:  state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign out_valid = (state_reg == ST_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            for (int i = 0; i < lhm_pkg::NUM_STAGES; i++)
            begin
                ev_reg[i]  <= '0;
                er_reg[i]  <= '0;
                sum_reg[i] <= '0;
                min_reg[i] <= '1;
                max_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_OBS)
            begin
                ev_reg[s] <= lhm_pkg::sat_inc(ev_reg[s]);
                if (!cur_reg.ok_flag)
                    er_reg[s] <= lhm_pkg::sat_inc(er_reg[s]);
                sum_reg[s] <= (sum_reg[s] > ~cur_reg.duration) ? '1
                              : sum_reg[s] + cur_reg.duration;
                if (cur_reg.duration < min_reg[s])
                    min_reg[s] <= cur_reg.duration;
                if (cur_reg.duration > max_reg[s])
                    max_reg[s] <= cur_reg.duration;
            end
        end
    end

    // Bin memory: one read, one write per cycle.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= bin_mem[rd_addr];
        if (state_reg == ST_CLR)
            bin_mem[clr_reg] <= '0;
        else if (state_reg == ST_OBS)
            bin_mem[base + lhm_pkg::ADDR_W'(cur_reg.bin)] <= lhm_pkg::sat_inc(rd_data_reg);
    end

    // Scaled target cnt*pct, one percentile per TGT1/TGT2 pass; also the bin scan and the result register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg  <= head;
            tsel_reg <= '0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_reg  <= '0;
                found_reg <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    seen_reg[k] <= '0;
                    pv_reg[k]   <= '0;
                end
            end
            ST_TGT1:
            begin
                tgt_reg[tsel_reg] <= lhm_pkg::PROD_W'(cnt) * lhm_pkg::PROD_W'(pct[tsel_reg]);
            end
            ST_TGT2:
            begin
                tsel_reg <= tsel_reg + 1'b1;
            end
            ST_SCAN:
            begin
                scan_reg <= scan_reg + 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    seen_reg[k] <= seen_n[k];
                    if (!found_reg[k] && seen_x100[k] >= tgt_reg[k])
                    begin
                        found_reg[k] <= 1'b1;
                        pv_reg[k]    <= (int'(scan_reg) < lhm_pkg::NUM_BOUNDS)
                                        ? lhm_pkg::bound_ns(scan_reg) : max_reg[s];
                    end
                end
            end
            ST_DONE:
            begin
                stage_echo  <= s;
                event_count <= cnt;
                error_count <= er_reg[s];
                latency_sum <= sum_reg[s];
                latency_min <= (cnt == '0) ? '0 : min_reg[s];
                latency_max <= (cnt == '0) ? '0 : max_reg[s];
                pct_first_value  <= (cnt == '0) ? '0 : (found_reg[0] ? pv_reg[0] : max_reg[s]);
                pct_second_value <= (cnt == '0) ? '0 : (found_reg[1] ? pv_reg[1] : max_reg[s]);
                pct_third_value  <= (cnt == '0) ? '0 : (found_reg[2] ? pv_reg[2] : max_reg[s]);
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/latency_histogram_monitor.sv */
// Top level of the latency histogram monitor: config registers, front, queue and back.
//
//   channel | direction | beat content
//   in      | input     | operation, stage, duration, ok_flag
//   out     | output    | stage_echo, counts, sum, min, max, three percentiles
//   apb     | input     | pct_first, pct_second, pct_third writes
//
// An item is held in the front register, where its bin is picked, then
// waits in the 4-entry queue. The back end handles an observe as a pop with the
// bin read, then the write; a query as the pop, TGT1 and TGT2 for each of the
// three targets, SCANW and SCAN for each of 18 bins, DONE to register the result
// and OUT for the beat, which waits for out_ready. After reset the bin memory is
// cleared, one entry a cycle, all 126 entries; no item leaves the queue meanwhile.
// A held result stalls the back; the queue fills, then in_ready drops.
`default_nettype none
module latency_histogram_monitor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          operation,
    input  wire logic [lhm_pkg::STAGE_W-1:0]   stage,
    input  wire logic [63:0]                   duration,
    input  wire logic                          ok_flag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lhm_pkg::STAGE_W-1:0]        stage_echo,
    output logic [63:0]                        event_count,
    output logic [63:0]                        error_count,
    output logic [63:0]                        latency_sum,
    output logic [63:0]                        latency_min,
    output logic [63:0]                        latency_max,
    output logic [63:0]                        pct_first_value,
    output logic [63:0]                        pct_second_value,
    output logic [63:0]                        pct_third_value
);
    logic [lhm_pkg::PCT_W-1:0] pct_first_reg, pct_second_reg, pct_third_reg;
    logic [1:0]                reg_idx;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_first_reg  <= lhm_pkg::PCT_FIRST_RST;
            pct_second_reg <= lhm_pkg::PCT_SECOND_RST;
            pct_third_reg  <= lhm_pkg::PCT_THIRD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                lhm_pkg::REG_PCT_FIRST:  pct_first_reg  <= pwdata[lhm_pkg::PCT_W-1:0];
                lhm_pkg::REG_PCT_SECOND: pct_second_reg <= pwdata[lhm_pkg::PCT_W-1:0];
                lhm_pkg::REG_PCT_THIRD:  pct_third_reg  <= pwdata[lhm_pkg::PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            lhm_pkg::REG_PCT_FIRST:  prdata = 32'(pct_first_reg);
            lhm_pkg::REG_PCT_SECOND: prdata = 32'(pct_second_reg);
            lhm_pkg::REG_PCT_THIRD:  prdata = 32'(pct_third_reg);
            default:                 prdata = '0;
        endcase
    end

    logic           push, q_full, pop, q_ne;
    lhm_pkg::work_t push_item, head;

    lhm_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .stage, .duration, .ok_flag,
        .push, .push_item, .q_full
    );

    lhm_queue u_queue (
        .clk, .rst_n, .push, .push_item, .full(q_full), .pop, .head, .not_empty(q_ne)
    );

    lhm_back u_back (
        .clk, .rst_n, .head, .not_empty(q_ne), .pop,
        .pct_first(pct_first_reg), .pct_second(pct_second_reg), .pct_third(pct_third_reg),
        .out_valid, .out_ready, .stage_echo, .event_count, .error_count, .latency_sum,
        .latency_min, .latency_max, .pct_first_value, .pct_second_value, .pct_third_value
    );
endmodule
`default_nettype wire
